>>> hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety check package
// Sizes, row types and control structs shared by the ring cells and the top.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int MAX_RESOURCES = 8;
   localparam int COUNT_BITS    = 16;
   localparam int WORK_BITS     = COUNT_BITS + 5;
   localparam int PROC_BITS     = $clog2(MAX_PROCESSES);
   localparam int RES_BITS      = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int CMP_BITS      = 8;

   localparam logic [1:0] MODE_LOAD_AVAIL = 2'd0;
   localparam logic [1:0] MODE_LOAD_NEED  = 2'd1;
   localparam logic [1:0] MODE_LOAD_ALLOC = 2'd2;
   localparam logic [1:0] MODE_RUN        = 2'd3;

   localparam logic [3:0] CSR_PROCESS_COUNT  = 4'd0;
   localparam logic [3:0] CSR_RESOURCE_COUNT = 4'd1;

   typedef logic [MAX_RESOURCES-1:0][COUNT_BITS-1:0] row_type;

   typedef struct packed {
      logic shift;
      logic clear_fin;
      logic we_need;
      logic we_alloc;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/bsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety check ring cell
// Holds the need row, allocation row and finish mark of one process and
// passes them to its neighbour when the ring rotates.
// ----------------------------------------------------------------------------
module bsc_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  bsc_pkg::cell_ctrl_type       ctrl,
   input  logic [bsc_pkg::RES_BITS-1:0] load_res,
   input  logic [bsc_pkg::COUNT_BITS-1:0] load_value,
   input  bsc_pkg::row_type             in_need,
   input  bsc_pkg::row_type             in_alloc,
   input  logic                         in_fin,
   output bsc_pkg::row_type             need,
   output bsc_pkg::row_type             alloc,
   output logic                         fin
);

   bsc_pkg::row_type need_ff;
   bsc_pkg::row_type alloc_ff;
   logic             fin_ff;
   logic             fin_in;

   always_comb begin
      fin_in = fin_ff;
      if (ctrl.clear_fin) begin
         fin_in = 1'b0;
      end else if (ctrl.shift) begin
         fin_in = in_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff  <= '0;
         alloc_ff <= '0;
      end else if (ctrl.shift) begin
         need_ff  <= in_need;
         alloc_ff <= in_alloc;
      end else begin
         if (ctrl.we_need) begin
            need_ff[load_res] <= load_value;
         end
         if (ctrl.we_alloc) begin
            alloc_ff[load_res] <= load_value;
         end
      end
   end

   assign need  = need_ff;
   assign alloc = alloc_ff;
   assign fin   = fin_ff;

endmodule

>>> hw/rtl/bankers_safety_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's algorithm safety check
// Ring of process cells rotating past one evaluation point at the head.
// ----------------------------------------------------------------------------
// Usage: a word on the req_ channel either loads one entry (available count,
// need entry or allocation entry) or starts a run. Loads give no result. A
// run yields one rsp_ word per process in the safe sequence and then a
// verdict word with rsp_last set.
// The process rows sit in a ring of cells that rotates one place per cycle
// while the result register is free; only the head cell is compared against
// the work vector. After each pick the rest of the pass over the ring is not
// evaluated, so that the next pass starts again at process 0.
// req_ready is low while a run is in progress. The csr_ channel is always
// ready. When the receiver stalls, the ring halts until the result register
// is free. Reset clears all tables, work, finish marks and the result valid
// flag, and sets the process and resource counts to their maximum.
// ----------------------------------------------------------------------------
module bankers_safety_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_process_index,
   input  logic [2:0]  req_resource_index,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_chosen_process,
   output logic        rsp_is_verdict,
   output logic        rsp_safe,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int NP = bsc_pkg::MAX_PROCESSES;
   localparam int NR = bsc_pkg::MAX_RESOURCES;
   localparam int CB = bsc_pkg::COUNT_BITS;
   localparam int WB = bsc_pkg::WORK_BITS;
   localparam int PB = bsc_pkg::PROC_BITS;
   localparam int XB = bsc_pkg::CMP_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         pc_ff;
   logic [3:0]         rc_ff;
   logic [CB-1:0]      avail_ff [NR];
   logic [WB-1:0]      work_ff  [NR];
   logic [WB-1:0]      work_in  [NR];
   logic [PB-1:0]      head_ff, head_in;
   logic               picked_ff, picked_in;
   logic [PB:0]        count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   logic [3:0]         out_proc_ff, out_proc_in;
   logic               out_verdict_ff, out_verdict_in;
   logic               out_safe_ff, out_safe_in;

   bsc_pkg::cell_ctrl_type ctrl [NP];
   bsc_pkg::row_type       need [NP];
   bsc_pkg::row_type       alloc [NP];
   logic                   fin [NP];
   logic                   tail_fin;

   logic               req_fire, out_free, step, fits, eval, wrap;
   logic [XB-1:0]      pc_eff, rc_eff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = (state_ff == ST_RUN) && out_free;
   assign wrap      = (head_ff == PB'(NP - 1));

   always_comb begin
      pc_eff = (XB'(pc_ff) > XB'(NP)) ? XB'(NP) : XB'(pc_ff);
      rc_eff = (XB'(rc_ff) > XB'(NR)) ? XB'(NR) : XB'(rc_ff);
   end

   always_comb begin
      fits = 1'b1;
      for (int r = 0; r < NR; r++) begin
         if ((XB'(r) < rc_eff) && (WB'(need[0][r]) > work_ff[r])) begin
            fits = 1'b0;
         end
      end
   end

   assign eval     = step && !picked_ff && (XB'(head_ff) < pc_eff) && !fin[0] && fits;
   assign tail_fin = fin[0] || eval;

   for (genvar k = 0; k < NP; k++) begin : g_cell
      always_comb begin
         ctrl[k].shift     = step;
         ctrl[k].clear_fin = req_fire && (req_mode == bsc_pkg::MODE_RUN);
         ctrl[k].we_need   = req_fire && (req_mode == bsc_pkg::MODE_LOAD_NEED)
                             && (XB'(req_process_index) == XB'(k))
                             && (XB'(req_resource_index) < XB'(NR));
         ctrl[k].we_alloc  = req_fire && (req_mode == bsc_pkg::MODE_LOAD_ALLOC)
                             && (XB'(req_process_index) == XB'(k))
                             && (XB'(req_resource_index) < XB'(NR));
      end

      bsc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[k]),
         .load_res   (bsc_pkg::RES_BITS'(req_resource_index)),
         .load_value (CB'(req_value)),
         .in_need    (need[(k + 1) % NP]),
         .in_alloc   (alloc[(k + 1) % NP]),
         .in_fin     ((k == NP - 1) ? tail_fin : fin[(k + 1) % NP]),
         .need       (need[k]),
         .alloc      (alloc[k]),
         .fin        (fin[k])
      );
   end

   always_comb begin
      logic [WB:0] sum;
      state_in       = state_ff;
      head_in        = head_ff;
      picked_in      = picked_ff;
      count_in       = count_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_proc_in    = out_proc_ff;
      out_verdict_in = out_verdict_ff;
      out_safe_in    = out_safe_ff;
      sum            = '0;
      for (int r = 0; r < NR; r++) begin
         work_in[r] = work_ff[r];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_mode == bsc_pkg::MODE_RUN)) begin
               state_in  = ST_RUN;
               head_in   = '0;
               picked_in = 1'b0;
               count_in  = '0;
               for (int r = 0; r < NR; r++) begin
                  work_in[r] = WB'(avail_ff[r]);
               end
            end
         end
         ST_RUN: begin
            if (step) begin
               if (eval) begin
                  picked_in      = 1'b1;
                  count_in       = count_ff + 1'b1;
                  out_valid_in   = 1'b1;
                  out_proc_in    = 4'(head_ff);
                  out_verdict_in = 1'b0;
                  out_safe_in    = 1'b0;
                  for (int r = 0; r < NR; r++) begin
                     if (XB'(r) < rc_eff) begin
                        sum = (WB + 1)'(work_ff[r]) + (WB + 1)'(alloc[0][r]);
                        work_in[r] = sum[WB] ? {WB{1'b1}} : sum[WB-1:0];
                     end
                  end
               end
               if (wrap) begin
                  head_in   = '0;
                  picked_in = 1'b0;
                  if (!picked_ff && !eval) begin
                     state_in       = ST_IDLE;
                     out_valid_in   = 1'b1;
                     out_proc_in    = '0;
                     out_verdict_in = 1'b1;
                     out_safe_in    = (XB'(count_ff) == pc_eff);
                  end
               end else begin
                  head_in = head_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         picked_ff    <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         pc_ff        <= 5'd16;
         rc_ff        <= 4'd8;
         for (int r = 0; r < NR; r++) begin
            avail_ff[r] <= '0;
            work_ff[r]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         picked_ff    <= picked_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         for (int r = 0; r < NR; r++) begin
            work_ff[r] <= work_in[r];
         end
         if (req_fire && (req_mode == bsc_pkg::MODE_LOAD_AVAIL)
             && (XB'(req_resource_index) < XB'(NR))) begin
            avail_ff[req_resource_index] <= CB'(req_value);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == bsc_pkg::CSR_PROCESS_COUNT) begin
               pc_ff <= csr_wdata[4:0];
            end else if (csr_index == bsc_pkg::CSR_RESOURCE_COUNT) begin
               rc_ff <= csr_wdata[3:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_proc_ff    <= out_proc_in;
      out_verdict_ff <= out_verdict_in;
      out_safe_ff    <= out_safe_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_chosen_process = out_proc_ff;
   assign rsp_is_verdict     = out_verdict_ff;
   assign rsp_safe           = out_safe_ff;
   assign rsp_last           = out_verdict_ff;

`ifndef SYNTH
   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (head_ff == '0))
      else $error("ring not aligned while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (XB'(count_ff) <= XB'(NP)))
      else $error("pick count exceeds process count");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_chosen_process)
                                     && $stable(rsp_is_verdict)))
      else $error("result word changed while stalled");

   a_verdict_ends_run: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && rsp_is_verdict) |-> (state_ff == ST_IDLE))
      else $error("verdict issued while run still active");
`endif

endmodule
